>>> hw/rtl/nvc_pkg.sv
package nvc_pkg;

    localparam int MAX_LEN     = 4096;
    localparam int CNT_W       = $clog2(MAX_LEN + 1);
    localparam int CH_W        = 8;
    localparam int MDIFF_W     = CH_W + 1;
    localparam int DIFF_W      = 14;
    localparam int CALC_W      = (CNT_W + 1 > DIFF_W) ? CNT_W + 1 : DIFF_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CH_W-1:0] ZERO_CH = 8'h30;
    localparam logic [CH_W-1:0] NINE_CH = 8'h39;

    typedef enum logic [1:0] {
        ORD_EQUAL  = 2'd0,
        ORD_FIRST  = 2'd1,
        ORD_SECOND = 2'd2
    } ord_t;

    // Classified character pair as it travels from the front to the back.
    typedef struct packed {
        logic                      last;
        logic                      eq;
        logic                      a_nul;
        logic                      a_dig;
        logic                      b_dig;
        logic                      a_zero;
        logic                      b_zero;
        logic signed [MDIFF_W-1:0] diff;
    } item_t;

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] x);
        return (x < CNT_W'(MAX_LEN)) ? x + CNT_W'(1) : x;
    endfunction

endpackage

>>> hw/rtl/nvc_front.sv
module nvc_front (
    input  logic [nvc_pkg::CH_W-1:0] char_a,
    input  logic [nvc_pkg::CH_W-1:0] char_b,
    input  logic                     last,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     q_full,
    output logic                     q_push,
    output nvc_pkg::item_t           q_item
);

    logic a_dig;
    logic b_dig;

    assign a_dig = (char_a >= nvc_pkg::ZERO_CH) && (char_a <= nvc_pkg::NINE_CH);
    assign b_dig = (char_b >= nvc_pkg::ZERO_CH) && (char_b <= nvc_pkg::NINE_CH);

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.last   = last;
        q_item.eq     = (char_a == char_b);
        q_item.a_nul  = (char_a == '0);
        q_item.a_dig  = a_dig;
        q_item.b_dig  = b_dig;
        q_item.a_zero = (char_a == nvc_pkg::ZERO_CH);
        q_item.b_zero = (char_b == nvc_pkg::ZERO_CH);
        q_item.diff   = $signed({1'b0, char_a}) - $signed({1'b0, char_b});
    end

endmodule

>>> hw/rtl/nvc_queue.sv
module nvc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nvc_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output nvc_pkg::item_t head_item
);

    nvc_pkg::item_t                   slot_reg [nvc_pkg::QUEUE_DEPTH];
    logic [nvc_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [nvc_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [nvc_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [nvc_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [nvc_pkg::QCNT_W-1:0]       count_reg;
    logic [nvc_pkg::QCNT_W-1:0]       count_next;

    function automatic logic [nvc_pkg::QPTR_W-1:0] ptr_inc(logic [nvc_pkg::QPTR_W-1:0] p);
        return (p == nvc_pkg::QPTR_W'(nvc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                 : p + nvc_pkg::QPTR_W'(1);
    endfunction

    assign full       = (count_reg == nvc_pkg::QCNT_W'(nvc_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + nvc_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - nvc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/nvc_back.sv
module nvc_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               head_valid,
    input  nvc_pkg::item_t                     head_item,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [nvc_pkg::DIFF_W-1:0]  difference,
    output logic [1:0]                         order
);

    localparam int CNT_W  = nvc_pkg::CNT_W;
    localparam int CALC_W = nvc_pkg::CALC_W;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'b001,
        PH_SCAN   = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [CNT_W-1:0] zeros;
        logic [CNT_W-1:0] run;
        logic             zact;
        logic             ract;
    } side_t;

    phase_t                              phase_reg;
    phase_t                              phase_next;
    logic [CNT_W-1:0]                    common_run_reg;
    logic [CNT_W-1:0]                    common_run_next;
    logic [CNT_W-1:0]                    common_zero_reg;
    logic [CNT_W-1:0]                    common_zero_next;
    logic                                all_zero_reg;
    logic                                all_zero_next;
    side_t                               first_reg;
    side_t                               first_next;
    side_t                               second_reg;
    side_t                               second_next;
    logic signed [nvc_pkg::MDIFF_W-1:0]  mdiff_reg;
    logic signed [nvc_pkg::MDIFF_W-1:0]  mdiff_next;
    logic signed [CALC_W-1:0]            decided_reg;
    logic signed [CALC_W-1:0]            decided_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [nvc_pkg::DIFF_W-1:0]   difference_reg;
    logic signed [nvc_pkg::DIFF_W-1:0]   difference_next;
    nvc_pkg::ord_t                       order_reg;
    nvc_pkg::ord_t                       order_next;

    logic                                produce;
    logic                                do_scan;
    side_t                               first_base;
    side_t                               second_base;
    side_t                               first_scan;
    side_t                               second_scan;

    function automatic side_t scan_side(side_t s, logic dig, logic zero);
        side_t r;
        r = s;
        if (s.zact)
        begin
            if (zero)
            begin
                r.zeros = nvc_pkg::sat_inc(s.zeros);
            end
            else
            begin
                r.zact = 1'b0;
                if ((s.zeros != '0) && !dig)
                begin
                    r.zeros = s.zeros - CNT_W'(1);
                end
            end
        end
        if (s.ract)
        begin
            if (dig)
            begin
                r.run = nvc_pkg::sat_inc(s.run);
            end
            else
            begin
                r.ract = 1'b0;
            end
        end
        return r;
    endfunction

    // A zero scan still open at the end of the strings sees the end byte,
    // which drops the final lone zero from the count.
    function automatic logic [CNT_W-1:0] end_zeros(side_t s);
        return (s.zact && (s.zeros != '0)) ? s.zeros - CNT_W'(1) : s.zeros;
    endfunction

    function automatic logic signed [CALC_W-1:0] decide(
        logic [CNT_W-1:0]                   zf,
        logic [CNT_W-1:0]                   zs,
        logic [CNT_W-1:0]                   rf,
        logic [CNT_W-1:0]                   rs,
        logic signed [nvc_pkg::MDIFF_W-1:0] md
    );
        logic signed [CALC_W-1:0] v;
        if (zf != zs)
        begin
            v = $signed(CALC_W'(zs) - CALC_W'(zf));
        end
        else if (zf != '0)
        begin
            v = CALC_W'(md);
        end
        else if (rf != rs)
        begin
            v = $signed(CALC_W'(rf) - CALC_W'(rs));
        end
        else
        begin
            v = CALC_W'(md);
        end
        return v;
    endfunction

    assign pop = head_valid && (!head_item.last || !out_valid_reg || !out_stall);
    assign produce = pop && head_item.last;

    assign out_valid  = out_valid_reg;
    assign difference = difference_reg;
    assign order      = order_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        common_run_next  = common_run_reg;
        common_zero_next = common_zero_reg;
        all_zero_next    = all_zero_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        mdiff_next       = mdiff_reg;
        decided_next     = decided_reg;
        do_scan          = 1'b0;
        first_base       = first_reg;
        second_base      = second_reg;

        if (pop)
        begin
            unique case (phase_reg)
                PH_PREFIX:
                begin
                    if (head_item.eq)
                    begin
                        if (head_item.a_nul)
                        begin
                            decided_next = '0;
                            phase_next   = PH_DONE;
                        end
                        else if (head_item.a_dig)
                        begin
                            if (all_zero_reg && head_item.a_zero)
                            begin
                                common_zero_next = nvc_pkg::sat_inc(common_zero_reg);
                            end
                            if (!head_item.a_zero)
                            begin
                                all_zero_next = 1'b0;
                            end
                            common_run_next = nvc_pkg::sat_inc(common_run_reg);
                        end
                        else
                        begin
                            common_run_next  = '0;
                            common_zero_next = '0;
                            all_zero_next    = 1'b1;
                        end
                    end
                    else
                    begin
                        mdiff_next = head_item.diff;
                        if ((common_run_reg == '0) && !(head_item.a_dig && head_item.b_dig))
                        begin
                            decided_next = CALC_W'(head_item.diff);
                            phase_next   = PH_DONE;
                        end
                        else
                        begin
                            // First mismatch inside or at the start of a digit run: both sides start
                            // from the common run, then scan this beat.
                            first_base.run   = common_run_reg;
                            first_base.ract  = 1'b1;
                            first_base.zact  = all_zero_reg;
                            first_base.zeros = all_zero_reg ? common_run_reg : common_zero_reg;
                            second_base      = first_base;
                            do_scan          = 1'b1;
                        end
                    end
                end
                PH_SCAN:
                begin
                    do_scan = 1'b1;
                end
                PH_DONE:
                begin
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end

        first_scan  = scan_side(first_base, head_item.a_dig, head_item.a_zero);
        second_scan = scan_side(second_base, head_item.b_dig, head_item.b_zero);

        if (do_scan)
        begin
            first_next  = first_scan;
            second_next = second_scan;
            mdiff_next  = (phase_reg == PH_PREFIX) ? head_item.diff : mdiff_reg;
            phase_next  = PH_SCAN;
            if (head_item.last
                || !(first_scan.zact || first_scan.ract
                     || second_scan.zact || second_scan.ract))
            begin
                decided_next = decide(end_zeros(first_scan), end_zeros(second_scan),
                                      first_scan.run, second_scan.run, mdiff_next);
                phase_next   = PH_DONE;
            end
        end

        difference_next = difference_reg;
        order_next      = order_reg;
        if (produce)
        begin
            difference_next = decided_next[nvc_pkg::DIFF_W-1:0];
            if (decided_next == '0)
            begin
                order_next = nvc_pkg::ORD_EQUAL;
            end
            else if (decided_next < 0)
            begin
                order_next = nvc_pkg::ORD_FIRST;
            end
            else
            begin
                order_next = nvc_pkg::ORD_SECOND;
            end
            phase_next       = PH_PREFIX;
            common_run_next  = '0;
            common_zero_next = '0;
            all_zero_next    = 1'b1;
            first_next       = '0;
            second_next      = '0;
            mdiff_next       = '0;
            decided_next     = '0;
        end

        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_PREFIX;
            common_run_reg  <= '0;
            common_zero_reg <= '0;
            all_zero_reg    <= 1'b1;
            first_reg       <= '0;
            second_reg      <= '0;
            mdiff_reg       <= '0;
            decided_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            common_run_reg  <= common_run_next;
            common_zero_reg <= common_zero_next;
            all_zero_reg    <= all_zero_next;
            first_reg       <= first_next;
            second_reg      <= second_next;
            mdiff_reg       <= mdiff_next;
            decided_reg     <= decided_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        difference_reg <= difference_next;
        order_reg      <= order_next;
    end

endmodule

>>> hw/rtl/natural_version_compare.sv
// A beat marked last waits in the queue; the back end pops it and registers its result.
// Throughput: one character pair per cycle while in_stall is low, set by the back end's
// state update; a two-entry queue lets the front keep taking beats while a result waits.
// Reset (rst_n, asynchronous, active low) empties the queue, clears the comparison state
// and drops out_valid; the block is ready for a new pair of strings right after it.
module natural_version_compare (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [nvc_pkg::CH_W-1:0]          char_a,
    input  logic [nvc_pkg::CH_W-1:0]          char_b,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [nvc_pkg::DIFF_W-1:0] difference,
    output logic [1:0]                        order
);

    logic           q_full;
    logic           q_push;
    nvc_pkg::item_t q_item;
    logic           q_pop;
    logic           head_valid;
    nvc_pkg::item_t head_item;

    nvc_front u_front (
        .char_a   (char_a),
        .char_b   (char_b),
        .last     (last),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    nvc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    nvc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .difference (difference),
        .order      (order)
    );

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import nvc_pkg::*;

    localparam int     HALF_PERIOD  = 6;
    localparam int     RANDOM_BEATS = 900;
    localparam int     DRAIN_CYCLES = 8;
    localparam longint TIMEOUT_NS   = 64'd20_000_000;

    typedef enum logic [1:0] {
        CMP_PREFIX,
        CMP_SCAN,
        CMP_DONE
    } cmp_phase_t;

    typedef struct packed {
        logic [DIFF_W-1:0] diff;
        ord_t              ord;
    } verdict_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [CH_W-1:0]          char_a    = '0;
    logic [CH_W-1:0]          char_b    = '0;
    logic                     last      = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DIFF_W-1:0] difference;
    logic [1:0]               order;

    natural_version_compare dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_a     (char_a),
        .char_b     (char_b),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .difference (difference),
        .order      (order)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Comparison state of the predictor.
    cmp_phase_t  cmp_phase    = CMP_PREFIX;
    int unsigned pre_run      = 0;
    int unsigned pre_zeros    = 0;
    bit          pre_all_zero = 1'b1;
    int unsigned zeros_a      = 0;
    int unsigned zeros_b      = 0;
    int unsigned run_a        = 0;
    int unsigned run_b        = 0;
    bit          zscan_a      = 1'b0;
    bit          zscan_b      = 1'b0;
    bit          rscan_a      = 1'b0;
    bit          rscan_b      = 1'b0;
    int          byte_diff    = 0;
    int          verdict      = 0;

    verdict_t        expected_verdicts[$];
    verdict_t        oldest_verdict;
    logic [CH_W-1:0] str_a[$];
    logic [CH_W-1:0] str_b[$];

    int error_count  = 0;
    int beats_sent   = 0;
    int results_seen = 0;

    // Sender and receiver pacing.
    int tx_gap_pct    = 0;
    int tx_burst_left = 0;
    int rx_stall_pct  = 0;
    int rx_hold       = 0;
    bit rx_stalling   = 1'b0;

    function automatic bit is_digit(logic [CH_W-1:0] c);
        return (c >= ZERO_CH) && (c <= NINE_CH);
    endfunction

    function automatic int unsigned bump(int unsigned x);
        return (x < MAX_LEN) ? x + 1 : MAX_LEN;
    endfunction

    function automatic void scan_char(input logic [CH_W-1:0] c, inout int unsigned zeros,
                                      inout int unsigned run, inout bit zon, inout bit ron);
        if (zon)
        begin
            if (c == ZERO_CH)
                zeros = bump(zeros);
            else
            begin
                zon = 1'b0;
                // A final lone zero of the run does not count as a leading zero.
                if (zeros > 0 && !is_digit(c))
                    zeros = zeros - 1;
            end
        end
        if (ron)
        begin
            if (is_digit(c))
                run = bump(run);
            else
                ron = 1'b0;
        end
    endfunction

    function automatic void clear_compare();
        cmp_phase    = CMP_PREFIX;
        pre_run      = 0;
        pre_zeros    = 0;
        pre_all_zero = 1'b1;
        zeros_a      = 0;
        zeros_b      = 0;
        run_a        = 0;
        run_b        = 0;
        zscan_a      = 1'b0;
        zscan_b      = 1'b0;
        rscan_a      = 1'b0;
        rscan_b      = 1'b0;
        byte_diff    = 0;
        verdict      = 0;
    endfunction

    function automatic void compare_char(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
        if (cmp_phase == CMP_DONE)
            return;
        if (cmp_phase == CMP_PREFIX)
        begin
            if (a == b)
            begin
                if (a == '0)
                begin
                    verdict   = 0;
                    cmp_phase = CMP_DONE;
                end
                else if (is_digit(a))
                begin
                    if (pre_all_zero && a == ZERO_CH)
                        pre_zeros = bump(pre_zeros);
                    if (a != ZERO_CH)
                        pre_all_zero = 1'b0;
                    pre_run = bump(pre_run);
                end
                else
                begin
                    pre_run      = 0;
                    pre_zeros    = 0;
                    pre_all_zero = 1'b1;
                end
                return;
            end
            byte_diff = int'(a) - int'(b);
            if (pre_run == 0 && !(is_digit(a) && is_digit(b)))
            begin
                verdict   = byte_diff;
                cmp_phase = CMP_DONE;
                return;
            end
            run_a   = pre_run;
            run_b   = pre_run;
            rscan_a = 1'b1;
            rscan_b = 1'b1;
            if (pre_all_zero)
            begin
                zeros_a = pre_run;
                zeros_b = pre_run;
                zscan_a = 1'b1;
                zscan_b = 1'b1;
            end
            else
            begin
                zeros_a = pre_zeros;
                zeros_b = pre_zeros;
                zscan_a = 1'b0;
                zscan_b = 1'b0;
            end
            cmp_phase = CMP_SCAN;
        end
        scan_char(a, zeros_a, run_a, zscan_a, rscan_a);
        scan_char(b, zeros_b, run_b, zscan_b, rscan_b);
        if (!zscan_a && !zscan_b && !rscan_a && !rscan_b)
        begin
            if (zeros_a != zeros_b)
                verdict = int'(zeros_b) - int'(zeros_a);
            else if (zeros_a > 0)
                verdict = byte_diff;
            else if (run_a != run_b)
                verdict = int'(run_a) - int'(run_b);
            else
                verdict = byte_diff;
            cmp_phase = CMP_DONE;
        end
    endfunction

    function automatic void predict_beat(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                         input logic l);
        verdict_t v;
        compare_char(a, b);
        if (!l)
            return;
        // A last beat with the comparison still undecided is followed by an implied end pair.
        if (cmp_phase != CMP_DONE)
            compare_char('0, '0);
        v.diff = verdict[DIFF_W-1:0];
        v.ord  = (verdict == 0) ? ORD_EQUAL : ((verdict < 0) ? ORD_FIRST : ORD_SECOND);
        expected_verdicts.push_back(v);
        clear_compare();
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 30)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Sends one beat; called at a rising edge, returns at the edge that accepted it.
    task automatic push_chars(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                              input logic l);
        if (tx_burst_left == 0)
        begin
            tx_burst_left = $urandom_range(1, 12);
            if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        tx_burst_left--;
        in_valid <= 1'b1;
        char_a   <= a;
        char_b   <= b;
        last     <= l;
        do
            @(posedge clk);
        while (in_stall);
        predict_beat(a, b, l);
        beats_sent++;
    endtask

    task automatic stream_strings();
        int              n;
        logic [CH_W-1:0] ca;
        logic [CH_W-1:0] cb;
        n = ((str_a.size() > str_b.size()) ? str_a.size() : str_b.size()) + 1;
        for (int i = 0; i < n; i++)
        begin
            ca = (i < str_a.size()) ? str_a[i] : '0;
            cb = (i < str_b.size()) ? str_b[i] : '0;
            push_chars(ca, cb, i == n - 1);
        end
    endtask

    task automatic compare_strings(input string s1, input string s2);
        str_a.delete();
        str_b.delete();
        for (int i = 0; i < s1.len(); i++)
            str_a.push_back(s1[i]);
        for (int i = 0; i < s2.len(); i++)
            str_b.push_back(s2[i]);
        stream_strings();
    endtask

    function automatic void put_char(input bit side, input logic [CH_W-1:0] c);
        if (side)
            str_b.push_back(c);
        else
            str_a.push_back(c);
    endfunction

    function automatic void fill_run(input bit side, input logic [CH_W-1:0] c, input int n);
        for (int i = 0; i < n; i++)
            put_char(side, c);
    endfunction

    function automatic void append_piece(input bit side);
        int    kind;
        int    n;
        string seps;
        seps = ".-_~+";
        kind = $urandom_range(0, 9);
        if (kind <= 4)
        begin
            fill_run(side, ZERO_CH, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                put_char(side, ZERO_CH + CH_W'($urandom_range(0, 9)));
        end
        else if (kind <= 6)
            put_char(side, seps[$urandom_range(0, 4)]);
        else if (kind <= 8)
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                put_char(side, 8'h61 + CH_W'($urandom_range(0, 25)));
        end
        else
            put_char(side, CH_W'($urandom_range(1, 255)));
    endfunction

    // Builds a version string and a relative of it that shares a random prefix.
    function automatic void make_version_pair();
        logic [CH_W-1:0] held[$];
        int              cut;
        int              mode;
        logic [CH_W-1:0] c;
        str_a.delete();
        str_b.delete();
        repeat ($urandom_range(1, 5)) append_piece(1'b0);
        cut  = $urandom_range(0, str_a.size());
        mode = $urandom_range(0, 9);
        for (int i = 0; i < cut; i++)
            str_b.push_back(str_a[i]);
        if (mode == 0)
        begin
            for (int i = cut; i < str_a.size(); i++)
                str_b.push_back(str_a[i]);
        end
        else if (mode <= 3 && cut < str_a.size())
        begin
            c = str_a[cut];
            if (is_digit(c))
                c = ZERO_CH + CH_W'($urandom_range(0, 9));
            else
                c = CH_W'($urandom_range(8'h21, 8'h7e));
            str_b.push_back(c);
            for (int i = cut + 1; i < str_a.size(); i++)
                str_b.push_back(str_a[i]);
        end
        else
            repeat ($urandom_range(0, 3)) append_piece(1'b1);
        if ($urandom_range(0, 1) == 1)
        begin
            held  = str_a;
            str_a = str_b;
            str_b = held;
        end
    endfunction

    function automatic logic [CH_W-1:0] noise_char();
        string pick;
        pick = "0019a.";
        if ($urandom_range(0, 1) == 0)
            return CH_W'($urandom_range(0, 255));
        return pick[$urandom_range(0, 5)];
    endfunction

    // Unframed traffic: random bytes with last at random, then an end beat to resync.
    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            push_chars(noise_char(), noise_char(), $urandom_range(0, 5) == 0);
        push_chars('0, '0, 1'b1);
    endtask

    task automatic set_pacing(input int gap_pct, input int stall_pct);
        tx_gap_pct   = gap_pct;
        rx_stall_pct = stall_pct;
    endtask

    task automatic test_equal_strings();
        set_pacing(0, 0);
        compare_strings("", "");
        compare_strings("1.2.3", "1.2.3");
    endtask

    task automatic test_byte_difference();
        set_pacing(30, 40);
        compare_strings("abc", "abd");
        compare_strings("a", "");
        compare_strings("9", "a");
        push_chars(8'hff, 8'h01, 1'b0);
        push_chars('0, '0, 1'b1);
        push_chars(8'h01, 8'hff, 1'b0);
        push_chars('0, '0, 1'b1);
        push_chars(8'hff, 8'h00, 1'b0);
        push_chars('0, '0, 1'b1);
    endtask

    task automatic test_digit_runs();
        set_pacing(50, 60);
        compare_strings("1.10", "1.9");
        compare_strings("1.9", "1.10");
        compare_strings("1.01", "1.1");
        compare_strings("1.001", "1.01");
        compare_strings("2.0", "2.00");
        compare_strings("0", "00");
        compare_strings("1.0a", "1.00");
        compare_strings("abc10", "abc9");
        compare_strings("000", "001");
        compare_strings("09", "0a");
    endtask

    task automatic test_early_last();
        set_pacing(0, 70);
        push_chars("1", "1", 1'b0);
        push_chars("2", "3", 1'b1);
        push_chars("0", "0", 1'b0);
        push_chars("5", "0", 1'b1);
        // Last inside the common prefix still leaves the strings equal.
        push_chars("7", "7", 1'b1);
    endtask

    task automatic test_decided_early();
        set_pacing(20, 0);
        push_chars("a", "a", 1'b0);
        push_chars("b", "c", 1'b0);
        push_chars("9", "0", 1'b0);
        push_chars(8'hff, 8'h80, 1'b0);
        push_chars("4", "2", 1'b1);
    endtask

    task automatic test_bytes_after_end();
        set_pacing(40, 30);
        push_chars("1", "1", 1'b0);
        push_chars("2", "3", 1'b0);
        push_chars('0, "4", 1'b0);
        push_chars("5", '0, 1'b0);
        push_chars('0, '0, 1'b1);
    endtask

    task automatic test_long_runs();
        set_pacing(0, 20);
        // Long common zero run on both sides.
        str_a.delete();
        str_b.delete();
        fill_run(1'b0, ZERO_CH, 120);
        fill_run(1'b1, ZERO_CH, 120);
        put_char(1'b0, "1");
        put_char(1'b1, "2");
        stream_strings();
        // A long leading-zero run against none.
        str_a.delete();
        str_b.delete();
        put_char(1'b0, "1");
        fill_run(1'b1, ZERO_CH, 60);
        put_char(1'b1, "5");
        stream_strings();
        // A long digit run against a short one.
        str_a.delete();
        str_b.delete();
        put_char(1'b0, "1");
        fill_run(1'b0, "2", 150);
        put_char(1'b1, "2");
        fill_run(1'b1, "3", 10);
        stream_strings();
    endtask

    task automatic test_random_mix();
        int start;
        int gap_opts[3]   = '{0, 30, 80};
        int stall_opts[4] = '{0, 25, 60, 90};
        start = beats_sent;
        set_pacing(0, 0);
        while (beats_sent - start < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 19) == 0)
                set_pacing(gap_opts[$urandom_range(0, 2)], stall_opts[$urandom_range(0, 3)]);
            if ($urandom_range(0, 4) != 0)
            begin
                make_version_pair();
                stream_strings();
            end
            else
                send_noise($urandom_range(1, 12));
        end
    endtask

    // The receiver holds each stall decision for a random number of cycles.
    always @(posedge clk)
    begin
        if (rx_hold == 0)
        begin
            rx_stalling = (rx_stall_pct != 0) && ($urandom_range(1, 100) <= rx_stall_pct);
            rx_hold     = $urandom_range(1, rx_stalling ? 5 : 10);
        end
        rx_hold--;
        out_stall <= rx_stalling;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_verdicts.size() == 0)
                report_error($sformatf("result beat with nothing expected: difference %0d",
                                       difference));
            else
            begin
                oldest_verdict = expected_verdicts.pop_front();
                if (difference !== oldest_verdict.diff)
                    report_error($sformatf("difference %0d, expected %0d", difference,
                                           $signed(oldest_verdict.diff)));
                if (order !== oldest_verdict.ord)
                    report_error($sformatf("order %0d, expected %0d", order,
                                           oldest_verdict.ord));
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results outstanding", expected_verdicts.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_equal_strings();
        test_byte_difference();
        test_digit_runs();
        test_early_last();
        test_decided_early();
        test_bytes_after_end();
        test_long_runs();
        test_random_mix();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Streamed %0d character pairs and checked %0d comparison results.",
                 beats_sent, results_seen);
        $display("Covered equal strings, byte differences, digit runs, leading zeros, early last,");
        $display("long digit runs and random version pairs under sender gaps and stalls.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/nvc_pkg.sv
hw/rtl/nvc_front.sv
hw/rtl/nvc_queue.sv
hw/rtl/nvc_back.sv
hw/rtl/natural_version_compare.sv
dv/tb.sv
